/* src/assert_macros.svh */
// Assertion helpers shared by the timer queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define DOTQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never occurs outside reset.
`define DOTQ_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* src/dotq_pkg.sv */
`default_nettype none

package dotq_pkg;

    localparam int unsigned TIME_W      = 63;
    localparam int unsigned ID_W        = 8;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS);

    localparam logic [TIME_W-1:0] MIN_DELAY_US = TIME_W'(100);

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_EXPIRE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXPIRED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE_DUE    = 3'd4;

    // One timer slot
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] when_us;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Operation driven into every cell
    typedef struct packed {
        logic ins;
        logic shl;
    } ctrl_t;

    // Operands broadcast to every cell
    typedef struct packed {
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] when_us;
        logic [ID_W-1:0]   id;
    } query_t;

endpackage

`default_nettype wire

/* src/dotq_cell.sv */
`default_nettype none

`include "assert_macros.svh"

module dotq_cell (
    input  wire              clk,
    input  wire              rst_n,
    input  dotq_pkg::ctrl_t  ctrl,
    input  dotq_pkg::query_t qry,
    input  dotq_pkg::entry_t prev_ent,
    input  wire              prev_later,
    input  dotq_pkg::entry_t next_ent,
    output dotq_pkg::entry_t ent,
    output logic             later,
    output logic             due,
    output logic             dup
);
    import dotq_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [TIME_W-1:0] when_reg;
    logic [TIME_W-1:0] when_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;

    // Compare the held timer against the broadcast operands
    always_comb
    begin
        later = !valid_reg || (when_reg > qry.when_us) ||
                ((when_reg == qry.when_us) && (id_reg > qry.id));
        due   = valid_reg && (when_reg <= qry.now_us);
        dup   = valid_reg && (id_reg == qry.id);
    end

    // Insert: take the neighbor's slot or the new timer; expire: advance left
    always_comb
    begin
        valid_next = valid_reg;
        when_next  = when_reg;
        id_next    = id_reg;
        if (ctrl.ins)
        begin
            if (prev_later)
            begin
                valid_next = prev_ent.valid;
                when_next  = prev_ent.when_us;
                id_next    = prev_ent.id;
            end
            else if (later)
            begin
                valid_next = 1'b1;
                when_next  = qry.when_us;
                id_next    = qry.id;
            end
        end
        else if (ctrl.shl)
        begin
            valid_next = next_ent.valid;
            when_next  = next_ent.when_us;
            id_next    = next_ent.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        when_reg <= when_next;
        id_reg   <= id_next;
    end

    assign ent = '{valid: valid_reg, when_us: when_reg, id: id_reg};

    // Occupied slots form a prefix of the row, in deadline order
    `DOTQ_NEVER(a_cell_prefix, clk, rst_n, valid_reg && !prev_ent.valid, "gap in row")
    `DOTQ_NEVER(a_cell_order, clk, rst_n, valid_reg && (prev_ent.when_us > when_reg), "row unsorted")
    // Insert and advance are never requested together
    `DOTQ_NEVER(a_cell_ctrl, clk, rst_n, ctrl.ins && ctrl.shl, "insert and advance together")

endmodule

`default_nettype wire

/* src/deadline_ordered_timer_queue.sv */
// Channel   Handshake              Ports
// -------   --------------------   ------------------------------------------------
// command   start & !busy          func, now_us, when_us, timer_id
// result    result_valid strobe    status, earlier, rearm_delay_us, expired_id,
//                                  expired_when_us, last
//
// An insert goes through S_IDLE and S_INS from accept to the next possible accept; its result
// shows in the cycle after the command is taken apart by the cell row.
// An expire gives one result beat per removed timer, or a single beat when nothing is due:
// the cell row advances one slot per cycle, so one timer leaves per cycle.
// Reset empties the row at once by clearing the valid bits; no sweep is needed.
// Each result beat is shown for a single cycle and cannot be held off; busy covers the work.
`default_nettype none

`include "assert_macros.svh"

module deadline_ordered_timer_queue #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire                             func,
    input  wire  [dotq_pkg::TIME_W-1:0]     now_us,
    input  wire  [dotq_pkg::TIME_W-1:0]     when_us,
    input  wire  [dotq_pkg::ID_W-1:0]       timer_id,
    output logic                            result_valid,
    output logic [dotq_pkg::STATUS_W-1:0]   status,
    output logic                            earlier,
    output logic [dotq_pkg::TIME_W-1:0]     rearm_delay_us,
    output logic [dotq_pkg::ID_W-1:0]       expired_id,
    output logic [dotq_pkg::TIME_W-1:0]     expired_when_us,
    output logic                            last
);
    import dotq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INS  = 3'b010,
        S_EXP  = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    query_t                qry_reg;
    query_t                qry_next;
    logic [RES_CNT_W-1:0]  cnt_reg;
    logic [RES_CNT_W-1:0]  cnt_next;

    logic                  rv_reg;
    logic                  rv_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic                  earlier_reg;
    logic                  earlier_next;
    logic [TIME_W-1:0]     delay_reg;
    logic [TIME_W-1:0]     delay_next;
    logic [ID_W-1:0]       xid_reg;
    logic [ID_W-1:0]       xid_next;
    logic [TIME_W-1:0]     xwhen_reg;
    logic [TIME_W-1:0]     xwhen_next;
    logic                  last_reg;
    logic                  last_next;

    ctrl_t                 ctrl;
    entry_t                ents   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] later_vec;
    logic [TABLE_DEPTH-1:0] due_vec;
    logic [TABLE_DEPTH-1:0] dup_vec;

    logic                  accept;
    logic                  any_dup;
    logic                  full;
    logic                  is_earliest;
    logic [TIME_W:0]       diff;
    logic [TIME_W-1:0]     delay_val;

    localparam entry_t HEAD_TIE = '{valid: 1'b1, when_us: '0, id: '0};
    localparam entry_t TAIL_TIE = '{valid: 1'b0, when_us: '0, id: '0};

    // Row of timer cells, earliest deadline in cell 0
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        dotq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .qry         (qry_reg),
            .prev_ent    ((i == 0) ? HEAD_TIE : ents[(i == 0) ? 0 : i-1]),
            .prev_later  ((i == 0) ? 1'b0 : later_vec[(i == 0) ? 0 : i-1]),
            .next_ent    ((i == TABLE_DEPTH-1) ? TAIL_TIE
                          : ents[(i == TABLE_DEPTH-1) ? i : i+1]),
            .ent         (ents[i]),
            .later       (later_vec[i]),
            .due         (due_vec[i]),
            .dup         (dup_vec[i])
        );
    end

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Insert checks and re-arm delay
    always_comb
    begin
        any_dup     = |dup_vec;
        full        = ents[TABLE_DEPTH-1].valid;
        is_earliest = !ents[0].valid || (ents[0].when_us > qry_reg.when_us);
        diff        = {1'b0, qry_reg.when_us} - {1'b0, qry_reg.now_us};
        if (diff[TIME_W] || (diff[TIME_W-1:0] < MIN_DELAY_US))
        begin
            delay_val = MIN_DELAY_US;
        end
        else
        begin
            delay_val = diff[TIME_W-1:0];
        end
    end

    // Sequencer: capture command, drive the row, form results
    always_comb
    begin
        state_next   = state_reg;
        qry_next     = qry_reg;
        cnt_next     = cnt_reg;
        ctrl         = '{ins: 1'b0, shl: 1'b0};
        rv_next      = 1'b0;
        status_next  = status_reg;
        earlier_next = earlier_reg;
        delay_next   = delay_reg;
        xid_next     = xid_reg;
        xwhen_next   = xwhen_reg;
        last_next    = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    qry_next = '{now_us: now_us, when_us: when_us, id: timer_id};
                    cnt_next = '0;
                    state_next = (func == FUNC_EXPIRE) ? S_EXP : S_INS;
                end
            end
            S_INS:
            begin
                rv_next      = 1'b1;
                earlier_next = 1'b0;
                delay_next   = '0;
                xid_next     = '0;
                xwhen_next   = '0;
                last_next    = 1'b1;
                if (any_dup)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next  = ST_INSERTED;
                    ctrl.ins     = 1'b1;
                    earlier_next = is_earliest;
                    delay_next   = is_earliest ? delay_val : '0;
                end
                state_next = S_IDLE;
            end
            S_EXP:
            begin
                rv_next      = 1'b1;
                earlier_next = 1'b0;
                delay_next   = '0;
                if (due_vec[0])
                begin
                    status_next = ST_EXPIRED;
                    xid_next    = ents[0].id;
                    xwhen_next  = ents[0].when_us;
                    ctrl.shl    = 1'b1;
                    last_next   = !due_vec[1] || (cnt_reg == RES_CNT_W'(MAX_RESULTS-1));
                    cnt_next    = cnt_reg + RES_CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NONE_DUE;
                    xid_next    = '0;
                    xwhen_next  = '0;
                    last_next   = 1'b1;
                end
                if (last_next)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qry_reg     <= qry_next;
        status_reg  <= status_next;
        earlier_reg <= earlier_next;
        delay_reg   <= delay_next;
        xid_reg     <= xid_next;
        xwhen_reg   <= xwhen_next;
        last_reg    <= last_next;
    end

    assign result_valid    = rv_reg;
    assign status          = status_reg;
    assign earlier         = earlier_reg;
    assign rearm_delay_us  = delay_reg;
    assign expired_id      = xid_reg;
    assign expired_when_us = xwhen_reg;
    assign last            = last_reg;

    // A result beat always follows a working cycle
    `DOTQ_ASSERT(a_res_after_work, clk, rst_n, result_valid |-> $past(busy), "stray result")
    // The final beat of an item frees the block; earlier beats keep it busy
    `DOTQ_ASSERT(a_last_frees, clk, rst_n, result_valid |-> (last != busy), "busy/last mismatch")
    // A taken command makes the block busy in the next cycle
    `DOTQ_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "command not taken")

endmodule

`default_nettype wire
